[hw/rtl/rx_agc_hysteresis_defines.svh]
// ----------------------------------------------------------------------------
// rx_agc_hysteresis_defines.svh
// Assertion macros used by the receive AGC RTL.
// ----------------------------------------------------------------------------
`ifndef RX_AGC_HYSTERESIS_DEFINES_SVH
`define RX_AGC_HYSTERESIS_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RXAGC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rx_agc_hysteresis assertion failed");

// Next-cycle implication, disabled in reset
`define RXAGC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rx_agc_hysteresis assertion failed");

`endif

[hw/rtl/rxagc_pkg.sv]
// ----------------------------------------------------------------------------
// rxagc_pkg
// Widths, constants, register indexes and the dB threshold table of the
// receive AGC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rxagc_pkg;

  localparam int PWR_W   = 31;
  localparam int GAIN_W  = 8;
  localparam int DB_W    = 7;
  localparam int COEF_W  = 11;
  localparam int TGT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Antennas taken into the max; only two power ports exist
  localparam int NUM_ANTENNAS = 2;

  localparam logic [COEF_W-1:0] Q10_ONE   = 11'd1024;
  localparam int                Q10_SHIFT = 10;
  localparam logic [GAIN_W:0]   GAIN_STEP = 9'd5;
  localparam logic [GAIN_W:0]   HYST_DB   = 9'd5;

  // Register reset values
  localparam logic [COEF_W-1:0] COEF_RST   = 11'd1024;
  localparam logic [TGT_W-1:0]  TGT_RST    = 7'd50;
  localparam logic [GAIN_W-1:0] MIN_G_RST  = 8'd0;
  localparam logic [GAIN_W-1:0] MAX_G_RST  = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_COEF = 2'd0,
    CFG_TARGET_DB   = 2'd1,
    CFG_MIN_GAIN    = 2'd2,
    CFG_MAX_GAIN    = 2'd3
  } cfg_idx_t;

  // Smallest power x with 10*log10(x) >= d, for d = 1 .. 93
  localparam int DB_TABLE_LEN = 93;
  localparam logic [PWR_W-1:0] DB_THR [DB_TABLE_LEN] = '{
    31'd2, 31'd2, 31'd2, 31'd3, 31'd4, 31'd4, 31'd6, 31'd7, 31'd8,
    31'd10, 31'd13, 31'd16, 31'd20, 31'd26, 31'd32, 31'd40, 31'd51, 31'd64,
    31'd80, 31'd100, 31'd126, 31'd159, 31'd200, 31'd252, 31'd317, 31'd399,
    31'd502, 31'd631, 31'd795, 31'd1000, 31'd1259, 31'd1585, 31'd1996,
    31'd2512, 31'd3163, 31'd3982, 31'd5012, 31'd6310, 31'd7944, 31'd10000,
    31'd12590, 31'd15849, 31'd19953, 31'd25119, 31'd31623, 31'd39811,
    31'd50119, 31'd63096, 31'd79433, 31'd100000, 31'd125893, 31'd158490,
    31'd199527, 31'd251189, 31'd316228, 31'd398108, 31'd501188, 31'd630958,
    31'd794329, 31'd1000000, 31'd1258926, 31'd1584894, 31'd1995263,
    31'd2511887, 31'd3162278, 31'd3981072, 31'd5011873, 31'd6309574,
    31'd7943283, 31'd10000000, 31'd12589255, 31'd15848932, 31'd19952624,
    31'd25118865, 31'd31622777, 31'd39810718, 31'd50118724, 31'd63095735,
    31'd79432824, 31'd100000000, 31'd125892542, 31'd158489320,
    31'd199526232, 31'd251188644, 31'd316227767, 31'd398107171,
    31'd501187234, 31'd630957345, 31'd794328235, 31'd1000000000,
    31'd1258925412, 31'd1584893193, 31'd1995262315
  };

endpackage

`default_nettype wire

[hw/rtl/rxagc_iir.sv]
// ----------------------------------------------------------------------------
// rxagc_iir
// One step of the Q10 power filter, or a direct load on clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rxagc_iir
  import rxagc_pkg::*;
(
  input  wire logic              clear,
  input  wire logic [PWR_W-1:0]  power,
  input  wire logic [PWR_W-1:0]  filt,
  input  wire logic [COEF_W-1:0] coef,
  output logic      [PWR_W-1:0]  filt_next
);

  // f*c + p*(1024-c) is rewritten as p*1024 + (f-p)*c: one multiplier
  logic [COEF_W-1:0]          coef_sat;
  logic signed [PWR_W:0]      diff;
  logic signed [PWR_W+COEF_W+1:0] prod;
  logic signed [PWR_W+COEF_W+1:0] acc;

  always_comb begin
    coef_sat = (coef > Q10_ONE) ? Q10_ONE : coef;
    diff     = signed'({1'b0, filt}) - signed'({1'b0, power});
    prod     = diff * signed'({1'b0, coef_sat});
    acc      = signed'({{(COEF_W+2-Q10_SHIFT){1'b0}}, power, {Q10_SHIFT{1'b0}}}) + prod;
    if (clear) begin
      filt_next = power;
    end else begin
      filt_next = acc[PWR_W+Q10_SHIFT-1:Q10_SHIFT];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rxagc_pw2db.sv]
// ----------------------------------------------------------------------------
// rxagc_pw2db
// Linear power to whole dB: floor(10*log10(x)), 0 below 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rxagc_pw2db
  import rxagc_pkg::*;
(
  input  wire logic [PWR_W-1:0] power,
  output logic      [DB_W-1:0]  power_db
);

  logic [(1<<DB_W)-1:0] therm;
  logic [DB_W-1:0]      pos;

  // Thresholds rise monotonically, so the compares form a thermometer
  // code whose length is the dB value. The length is resolved from the
  // top bit down, one thermometer lookup per output bit.
  always_comb begin
    therm = '0;
    for (int i = 0; i < DB_TABLE_LEN; i++) begin
      therm[i] = (power >= DB_THR[i]);
    end
    power_db = '0;
    pos      = '0;
    for (int k = DB_W-1; k >= 0; k--) begin
      pos         = power_db | DB_W'((1 << k) - 1);
      power_db[k] = therm[pos];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rx_agc_hysteresis.sv]
// ----------------------------------------------------------------------------
// rx_agc_hysteresis
// Receive AGC: max of antenna powers, Q10 IIR power filter, dB conversion
// and a +/-5 dB gain step with a +/-5 dB dead band around the target.
// ----------------------------------------------------------------------------
//   channel  signals                                     direction
//   in       in_valid/in_ready, clear_filter, power_ant*  into block
//   out      out_valid/out_ready, gain_db, filtered_power*  out of block
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     into block
//
// Three register stages: input register, filter stage, result register.
// One item per cycle sustained while out does not stall, set by the filter
// multiplier loop in the filter stage.
// Synchronous reset clears valids, filter and gain state, and sets the configuration registers to their reset values.
// A stall on out backs up stage by stage; in_ready falls only when all
// three stages are full. cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rx_agc_hysteresis_defines.svh"

module rx_agc_hysteresis
  import rxagc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  clear_filter,
  input  wire logic [PWR_W-1:0]      power_ant0,
  input  wire logic [PWR_W-1:0]      power_ant1,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [GAIN_W-1:0]     gain_db,
  output logic      [PWR_W-1:0]      filtered_power,
  output logic      [DB_W-1:0]       filtered_power_db,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [COEF_W-1:0] filter_coef;
  logic [TGT_W-1:0]  target_power_db;
  logic [GAIN_W-1:0] min_gain_db;
  logic [GAIN_W-1:0] max_gain_db;

  // input register
  logic             inr_valid;
  logic             inr_clear;
  logic [PWR_W-1:0] inr_power;

  // filter stage; filt_state is both the filter state and its payload
  logic             s1_valid;
  logic [PWR_W-1:0] filt_state;
  logic [PWR_W-1:0] filt_state_next;

  // result register; gain_reg is both the gain state and the result
  logic              gain_state;
  logic [GAIN_W-1:0] gain_reg;
  logic [GAIN_W-1:0] gain_reg_next;
  logic [DB_W-1:0]   fdb;

  logic             load_out;
  logic             load_s1;
  logic             s1_free;
  logic             in_acc;
  logic [PWR_W-1:0] power_max;

  assign gain_state = 1'b0;

  // stage handshakes
  assign load_out = s1_valid && (!out_valid || out_ready);
  assign s1_free  = !s1_valid || load_out;
  assign load_s1  = inr_valid && s1_free;
  assign in_ready = !inr_valid || load_s1;
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_coef     <= COEF_RST;
      target_power_db <= TGT_RST;
      min_gain_db     <= MIN_G_RST;
      max_gain_db     <= MAX_G_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILTER_COEF: filter_coef     <= cfg_data[COEF_W-1:0];
        CFG_TARGET_DB:   target_power_db <= cfg_data[TGT_W-1:0];
        CFG_MIN_GAIN:    min_gain_db     <= cfg_data[GAIN_W-1:0];
        CFG_MAX_GAIN:    max_gain_db     <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // largest antenna power
  always_comb begin
    power_max = power_ant0;
    if (NUM_ANTENNAS > 1 && power_ant1 > power_ant0) begin
      power_max = power_ant1;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inr_valid <= 1'b0;
    end else if (in_ready) begin
      inr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      inr_clear <= clear_filter;
      inr_power <= power_max;
    end
  end

  // filter stage
  rxagc_iir u_iir (
    .clear     (inr_clear),
    .power     (inr_power),
    .filt      (filt_state),
    .coef      (filter_coef),
    .filt_next (filt_state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      filt_state <= '0;
    end else begin
      if (s1_free) begin
        s1_valid <= inr_valid;
      end
      if (load_s1) begin
        filt_state <= filt_state_next;
      end
    end
  end

  // dB conversion of the new filtered power
  rxagc_pw2db u_pw2db (
    .power    (filt_state),
    .power_db (fdb)
  );

  // gain step with dead band around the target
  always_comb begin
    logic [GAIN_W:0] g_up;
    logic [GAIN_W:0] db_w;
    logic [GAIN_W:0] tgt_w;
    g_up  = {1'b0, gain_reg} + GAIN_STEP;
    db_w  = {{(GAIN_W+1-DB_W){1'b0}}, fdb};
    tgt_w = {{(GAIN_W+1-TGT_W){1'b0}}, target_power_db};
    gain_reg_next = gain_reg;
    priority if (db_w + HYST_DB < tgt_w && gain_reg < max_gain_db) begin
      gain_reg_next = (g_up > {1'b0, max_gain_db}) ? max_gain_db : g_up[GAIN_W-1:0];
    end else if (db_w > tgt_w + HYST_DB && gain_reg > min_gain_db) begin
      gain_reg_next = ({1'b0, gain_reg} < {1'b0, min_gain_db} + GAIN_STEP) ?
                      min_gain_db : GAIN_W'({1'b0, gain_reg} - GAIN_STEP);
    end else begin
      // inside the dead band or already at the limit: hold
      gain_reg_next = gain_reg;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      gain_reg  <= '0;
    end else begin
      if (!out_valid || out_ready) begin
        out_valid <= s1_valid;
      end
      if (load_out) begin
        gain_reg <= gain_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered_power    <= filt_state;
      filtered_power_db <= fdb;
    end
  end

  assign gain_db = gain_reg ^ {GAIN_W{gain_state}};

  // filter state moves only when an item enters the filter stage
  `RXAGC_ASSERT_NXT(a_filt_hold, clk, rst, !load_s1, $stable(filt_state))
  // a clear item loads its max power straight into the filter
  `RXAGC_ASSERT_NXT(a_clear_load, clk, rst, load_s1 && inr_clear,
                    filt_state == $past(inr_power))
  // gain moves only when a result is produced
  `RXAGC_ASSERT_NXT(a_gain_hold, clk, rst, !load_out, $stable(gain_reg))

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: receive AGC regression
// Feeds antenna power measurements through the AGC over a series of filter,
// target and gain-limit settings. A scoreboard predicts gain, filtered power
// and its whole-dB value for every accepted item, using exact integer dB
// math, and checks each result in order. Both handshakes see random gaps,
// a long output stall, and drained pauses for register writes.
// ----------------------------------------------------------------------------
module tb;
  import rxagc_pkg::*;

  localparam int LONG_HOLD   = 60;      // output hold-off, in cycles
  localparam int SETTLE      = 8;       // pipeline latency plus margin
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 133;
  localparam logic [PWR_W-1:0] PWR_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [PWR_W-1:0]  fpow;
    logic [DB_W-1:0]   fdb;
  } agc_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: AGC predictor plus in-order result queue
  // --------------------------------------------------------------------------
  class agc_scoreboard;
    localparam int Q10_UNIT  = 1024;
    localparam int GAIN_STEP_DB = 5;
    localparam int DEAD_BAND_DB = 5;
    localparam int DB_TOP    = 93;

    int coef, target_db, gain_lo, gain_hi;
    logic [PWR_W-1:0] filt_pwr;
    int gain;
    agc_result_t expected_results[$];
    logic [319:0] pow10 [DB_TOP+1];
    int mismatch_count, checked, clears, up_clamps, down_clamps;

    function new();
      coef = 1024; target_db = 50; gain_lo = 0; gain_hi = 120;
      filt_pwr = '0; gain = 0;
      mismatch_count = 0; checked = 0; clears = 0; up_clamps = 0; down_clamps = 0;
      pow10[0] = 320'd1;
      for (int d = 1; d <= DB_TOP; d++) pow10[d] = pow10[d-1] * 320'd10;
    endfunction

    // floor(10*log10(x)) exactly: largest d with x^10 >= 10^d, 0 for x = 0
    function int db_floor(logic [PWR_W-1:0] x);
      logic [319:0] x10;
      int r;
      r = 0;
      x10 = 320'(x);
      for (int k = 1; k < 10; k++) x10 = x10 * 320'(x);
      for (int d = 0; d <= DB_TOP; d++) if (x10 >= pow10[d]) r = d;
      return r;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_FILTER_COEF: coef      = int'(v[10:0]);
        CFG_TARGET_DB:   target_db = int'(v[6:0]);
        CFG_MIN_GAIN:    gain_lo   = int'(v[7:0]);
        CFG_MAX_GAIN:    gain_hi   = int'(v[7:0]);
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted measurement item
    function void note_measurement(bit clr, logic [PWR_W-1:0] p0, logic [PWR_W-1:0] p1);
      logic [PWR_W-1:0] peak;
      logic [63:0] acc;
      int c, fdb;
      agc_result_t r;
      peak = p0;
      if (NUM_ANTENNAS > 1 && p1 > p0) peak = p1;
      if (clr) begin
        filt_pwr = peak;
        clears++;
      end else begin
        c = (coef > Q10_UNIT) ? Q10_UNIT : coef;
        acc = 64'(filt_pwr) * 64'(c) + 64'(peak) * 64'(Q10_UNIT - c);
        filt_pwr = acc[40:10];
      end
      fdb = db_floor(filt_pwr);
      // hysteresis gain step with clamping
      if (fdb < target_db - DEAD_BAND_DB && gain < gain_hi) begin
        gain = gain + GAIN_STEP_DB;
        if (gain > gain_hi) begin
          gain = gain_hi;
          up_clamps++;
        end
      end else if (fdb > target_db + DEAD_BAND_DB && gain > gain_lo) begin
        gain = gain - GAIN_STEP_DB;
        if (gain < gain_lo) begin
          gain = gain_lo;
          down_clamps++;
        end
      end
      r.gain = GAIN_W'(gain);
      r.fpow = filt_pwr;
      r.fdb  = DB_W'(fdb);
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t ns  MISMATCH  %s", $time, msg);
      mismatch_count++;
    endtask

    task check_result(logic [GAIN_W-1:0] g, logic [PWR_W-1:0] fp, logic [DB_W-1:0] fdb);
      agc_result_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("result with none pending: gain %0d power %0d dB %0d", g, fp, fdb));
      end else begin
        e = expected_results.pop_front();
        if (g !== e.gain)
          report($sformatf("item %0d gain_db %0d, want %0d", checked, g, e.gain));
        if (fp !== e.fpow)
          report($sformatf("item %0d filtered_power %0d, want %0d", checked, fp, e.fpow));
        if (fdb !== e.fdb)
          report($sformatf("item %0d filtered_power_db %0d, want %0d", checked, fdb, e.fdb));
      end
      checked++;
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, clear_filter;
  logic [PWR_W-1:0] power_ant0, power_ant1;
  logic out_valid, out_ready;
  logic [GAIN_W-1:0] gain_db;
  logic [PWR_W-1:0] filtered_power;
  logic [DB_W-1:0] filtered_power_db;
  logic cfg_valid, cfg_ready;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  agc_scoreboard sb;
  bit tx_idle_en, rx_stall_en, long_hold_req;
  int items_sent, settings_used;

  rx_agc_hysteresis dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .clear_filter(clear_filter),
    .power_ant0(power_ant0), .power_ant1(power_ant1),
    .out_valid(out_valid), .out_ready(out_ready), .gain_db(gain_db),
    .filtered_power(filtered_power), .filtered_power_db(filtered_power_db),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Run limit
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(gain_db, filtered_power, filtered_power_db);
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  task send_measurement(bit clr, logic [PWR_W-1:0] a, logic [PWR_W-1:0] b);
    int gap;
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    clear_filter <= clr;
    power_ant0 <= a;
    power_ant1 <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_measurement(clr, a, b);
    items_sent++;
  endtask

  // Stop offering items and wait until every result is back
  task drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_agc_reg(cfg_idx_t idx, int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(v);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, CFG_DATA_W'(v));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task apply_settings(int coef, int tgt, int lo, int hi);
    drain_pipeline();
    write_agc_reg(CFG_FILTER_COEF, coef);
    write_agc_reg(CFG_TARGET_DB, tgt);
    write_agc_reg(CFG_MIN_GAIN, lo);
    write_agc_reg(CFG_MAX_GAIN, hi);
    settings_used++;
  endtask

  // Log-spread power around a level, with occasional full-range noise
  function logic [PWR_W-1:0] draw_power(int shift);
    case ($urandom_range(0, 7))
      0: return PWR_W'($urandom);
      1: return PWR_W'($urandom_range(0, 3));
      default: return PWR_W'($urandom >> shift);
    endcase
  endfunction

  // Segments of items held near one power level so the gain walks far
  task run_random_items(int count);
    int seg, shift;
    while (count > 0) begin
      seg = $urandom_range(10, 30);
      shift = $urandom_range(1, 31);
      while (seg > 0 && count > 0) begin
        send_measurement($urandom_range(0, 7) == 0, draw_power(shift), draw_power(shift));
        seg--;
        count--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int ph_coef [8] = '{1000, 900, 0, 2047, 1024, 700, 980, 512};
  int ph_tgt  [8] = '{50, 40, 30, 60, 4, 60, 94, 20};
  int ph_lo   [8] = '{0, 20, 0, 0, 0, 200, 0, 100};
  int ph_hi   [8] = '{120, 60, 255, 255, 255, 100, 10, 255};

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    clear_filter = 1'b0;
    power_ant0 = '0;
    power_ant1 = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FILTER_COEF;
    cfg_data = '0;
    tx_idle_en = 1'b0;
    rx_stall_en = 1'b1;
    long_hold_req = 1'b0;
    items_sent = 0;
    settings_used = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, clears, power extremes and dB thresholds
    send_measurement(1'b1, 31'd0, 31'd0);
    send_measurement(1'b1, 31'd1, 31'd0);
    send_measurement(1'b1, 31'd0, 31'd2);
    send_measurement(1'b1, PWR_MAX, 31'd0);
    send_measurement(1'b1, 31'd0, PWR_MAX);
    send_measurement(1'b1, 31'h2AAAAAAA, 31'h55555555);
    send_measurement(1'b1, 31'h55555555, 31'h2AAAAAAA);
    send_measurement(1'b0, PWR_MAX, PWR_MAX);        // full weight on old: holds
    send_measurement(1'b1, 31'd1995262315, 31'd0);
    send_measurement(1'b1, 31'd1995262314, 31'd0);
    send_measurement(1'b1, 31'd0, 31'd9);
    send_measurement(1'b1, 31'd10, 31'd10);
    send_measurement(1'b1, 31'd99999, 31'd1);
    send_measurement(1'b1, 31'd100000, 31'd0);
    // zero coefficient: filter tracks input; target below dead band
    apply_settings(0, 0, 0, 255);
    send_measurement(1'b0, PWR_MAX, 31'd5);
    send_measurement(1'b0, 31'd3, 31'd0);
    send_measurement(1'b0, 31'd0, 31'd0);
    // coefficient above unity saturates
    apply_settings(1500, 94, 10, 200);
    send_measurement(1'b0, 31'd0, PWR_MAX);
    send_measurement(1'b1, 31'd0, 31'd12345);
    // half weight, top target, min write with upper data bits set
    apply_settings(512, 127, 2047, 255);
    send_measurement(1'b1, PWR_MAX, 31'd0);
    send_measurement(1'b0, 31'd0, 31'd0);
    send_measurement(1'b0, PWR_MAX, PWR_MAX);

    // Random phases under a spread of settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 8)
        apply_settings(ph_coef[ph], ph_tgt[ph], ph_lo[ph], ph_hi[ph]);
      else
        apply_settings($urandom_range(0, 2047), $urandom_range(0, 127),
                       $urandom_range(0, 2047), $urandom_range(0, 2047));
      tx_idle_en = (ph < NUM_PHASES - 1);
      rx_stall_en = (ph < NUM_PHASES - 1);
      if (ph == 1) long_hold_req = 1'b1;   // sender keeps going into a full block
      if (ph == 3) begin
        run_random_items(PHASE_ITEMS / 2);
        drain_pipeline();                  // sender pause until all results back
        run_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_random_items(PHASE_ITEMS);
      end
    end

    drain_pipeline();
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d items under %0d register settings, %0d filter clears.",
             items_sent, settings_used, sb.clears);
    $display("Checked %0d results; gain clamped at max %0d times, at min %0d times.",
             sb.checked, sb.up_clamps, sb.down_clamps);
    if (sb.mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
